/* hdl/pto_pkg.sv */
// Package for the pulse tachometer / odometer core.
// Widths, register indexes, constants and the divider result type.
// No dependencies; imported by pto_div, pulse_tachometer_odometer_core, odometer_check and tb.
package pto_pkg;

    localparam int TIME_W   = 32;
    localparam int DIST_W   = 48;
    localparam int FREQ_W   = 20;
    localparam int RPM_W    = 26;
    localparam int VEL_W    = 25;
    localparam int STROKE_W = 16;
    localparam int DEB_W    = 20;
    localparam int QUIET_W  = 20;
    localparam int IDLE_W   = 22;
    localparam int CFG_W    = 32;
    localparam int PROD_W   = 64;
    localparam int CNT_W    = $clog2(FREQ_W + 1);

    // 1e6 / period gives the frequency in hertz
    localparam logic [FREQ_W-1:0] FREQ_NUM = FREQ_W'(1000000);

    // floor(x / 5) = (x * 0xCCCCCCCD) >> 34 for any x below 2^32
    localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
    localparam int RECIP5_SHIFT = 34;
    // /2560 = /512 then /5
    localparam int VEL_SHIFT = 9;

    localparam logic [STROKE_W-1:0] STROKE_RST = STROKE_W'(896);
    localparam logic [DEB_W-1:0]    DEB_RST    = DEB_W'(1000);
    localparam logic [QUIET_W-1:0]  QUIET_RST  = QUIET_W'(1000);
    localparam logic [IDLE_W-1:0]   IDLE_RST   = IDLE_W'(30000);

    typedef enum logic [1:0] {
        CFG_STROKE   = 2'd0,
        CFG_DEBOUNCE = 2'd1,
        CFG_QUIET    = 2'd2,
        CFG_IDLE     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic              done;
        logic [FREQ_W-1:0] quotient;
    } div_result_t;

endpackage

/* hdl/pto_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on pto_pkg (widths, div_result_t).
module pto_div import pto_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [FREQ_W-1:0] dividend,
    input  logic [TIME_W-1:0] divisor,
    output div_result_t       result
);

    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [FREQ_W-1:0] quo_reg, quo_next;
    logic [TIME_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;

    always_comb begin
        trial = {rem_reg, quo_reg[FREQ_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[TIME_W]) begin
                rem_next = diff[TIME_W-1:0];
                quo_next = {quo_reg[FREQ_W-2:0], 1'b1};
            end else begin
                rem_next = trial[TIME_W-1:0];
                quo_next = {quo_reg[FREQ_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(FREQ_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign result.done     = done_reg;
    assign result.quotient = quo_reg;

endmodule

/* hdl/pulse_tachometer_odometer_core.sv */
// Pulse tachometer / odometer core: top level with sequencer and shared multiplier.
// Depends on pto_pkg and pto_div.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | s_valid / s_ready      | s_time_us, s_time_ms, s_edge_req, s_poll
//  result   | m_valid / m_ready      | m_frequency_hz .. m_signal_active (7 fields)
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A transaction without poll passes the edge and plan states to the write-out; a poll
// with a zero period adds the check state; a poll with a nonzero period waits in the
// divide state for the radix-2 divider's 1e6/period (20 quotient bits, then its done
// flag), followed by three passes through the one 32x32 multiplier.
// s_ready is high only while the sequencer is idle. The result register frees the
// sequencer: a held result only stalls the next transaction at its final write-out.
// Reset is synchronous, active low; no clearing pass. cfg_ready is always high.
module pulse_tachometer_odometer_core import pto_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [TIME_W-1:0] s_time_us,
    input  logic [TIME_W-1:0] s_time_ms,
    input  logic              s_edge_req,
    input  logic              s_poll,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [FREQ_W-1:0] m_frequency_hz,
    output logic [RPM_W-1:0]  m_rpm_value,
    output logic [VEL_W-1:0]  m_velocity,
    output logic [DIST_W-1:0] m_distance_10um,
    output logic [TIME_W-1:0] m_hole_count,
    output logic [TIME_W-1:0] m_active_time_ms,
    output logic              m_signal_active,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_PLAN,
        ST_DIV,
        ST_MUL_VEL,
        ST_MUL_DIV5,
        ST_VEL,
        ST_MUL_DIST,
        ST_ACC,
        ST_CHECK,
        ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [STROKE_W-1:0] stroke_reg;
    logic [DEB_W-1:0]    debounce_reg;
    logic [QUIET_W-1:0]  quiet_reg;
    logic [IDLE_W-1:0]   idle_reg;

    // latched transaction
    logic [TIME_W-1:0] in_us_reg;
    logic [TIME_W-1:0] in_ms_reg;
    logic              in_edge_reg;
    logic              in_poll_reg;

    // measurement state
    logic [TIME_W-1:0] prev_edge_reg;
    logic [TIME_W-1:0] accepted_edge_reg;
    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] last_pulse_reg;
    logic [TIME_W-1:0] pulse_total_reg;
    logic              active_reg;
    logic [TIME_W-1:0] active_start_reg;
    logic [TIME_W-1:0] active_accum_reg;
    logic [TIME_W-1:0] last_dist_ms_reg;
    logic [DIST_W-1:0] distance_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [RPM_W-1:0]  rpm_reg;
    logic [VEL_W-1:0]  velocity_reg;
    logic              pulse_seen_reg;
    logic              dist_seen_reg;

    // result register
    logic              m_valid_reg;
    logic [FREQ_W-1:0] m_freq_reg;
    logic [RPM_W-1:0]  m_rpm_reg;
    logic [VEL_W-1:0]  m_vel_reg;
    logic [DIST_W-1:0] m_dist_reg;
    logic [TIME_W-1:0] m_holes_reg;
    logic [TIME_W-1:0] m_active_ms_reg;
    logic              m_active_reg;

    // shared multiplier, product registered
    logic [31:0]       mul_a, mul_b;
    logic [PROD_W-1:0] prod_reg;

    // divider
    logic        div_start;
    div_result_t div_res;

    logic [TIME_W-1:0] edge_gap;
    logic [TIME_W-1:0] quiet_gap;
    logic [TIME_W-1:0] dist_gap;
    logic [RPM_W-1:0]  rpm_calc;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign div_start = (state_reg == ST_PLAN) && in_poll_reg && (period_reg != '0);

    pto_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (FREQ_NUM),
        .divisor  (period_reg),
        .result   (div_res)
    );

    assign edge_gap  = in_us_reg - prev_edge_reg;
    assign quiet_gap = in_ms_reg - last_pulse_reg;
    assign dist_gap  = in_ms_reg - last_dist_ms_reg;
    // f * 60 = f * 64 - f * 4
    assign rpm_calc  = (RPM_W'(div_res.quotient) << 6) - (RPM_W'(div_res.quotient) << 2);

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_VEL: begin
                mul_a = 32'(freq_reg);
                mul_b = 32'(stroke_reg);
            end
            ST_MUL_DIV5: begin
                mul_a = 32'(prod_reg[VEL_SHIFT +: 27]);
                mul_b = RECIP5;
            end
            ST_MUL_DIST: begin
                mul_a = 32'(velocity_reg);
                mul_b = dist_gap;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stroke_reg   <= STROKE_RST;
            debounce_reg <= DEB_RST;
            quiet_reg    <= QUIET_RST;
            idle_reg     <= IDLE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_STROKE:   stroke_reg   <= cfg_data[STROKE_W-1:0];
                CFG_DEBOUNCE: debounce_reg <= cfg_data[DEB_W-1:0];
                CFG_QUIET:    quiet_reg    <= cfg_data[QUIET_W-1:0];
                CFG_IDLE:     idle_reg     <= cfg_data[IDLE_W-1:0];
            endcase
        end
    end

    // sequencer: state, measurement state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            prev_edge_reg     <= '0;
            accepted_edge_reg <= '0;
            period_reg        <= '0;
            last_pulse_reg    <= '0;
            pulse_total_reg   <= '0;
            active_reg        <= 1'b0;
            active_start_reg  <= '0;
            active_accum_reg  <= '0;
            last_dist_ms_reg  <= '0;
            distance_reg      <= '0;
            freq_reg          <= '0;
            rpm_reg           <= '0;
            velocity_reg      <= '0;
            pulse_seen_reg    <= 1'b0;
            dist_seen_reg     <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            // ST_OUT decides m_valid itself when it loads a new result
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_us_reg   <= s_time_us;
                        in_ms_reg   <= s_time_ms;
                        in_edge_reg <= s_edge_req;
                        in_poll_reg <= s_poll;
                        state_reg   <= ST_EDGE;
                    end
                end
                ST_EDGE: begin
                    // debounce on the wrapped gap since the last accepted edge
                    if (in_edge_reg && (edge_gap >= TIME_W'(debounce_reg))) begin
                        prev_edge_reg     <= in_us_reg;
                        period_reg        <= in_us_reg - accepted_edge_reg;
                        accepted_edge_reg <= in_us_reg;
                        last_pulse_reg    <= in_ms_reg;
                        pulse_seen_reg    <= 1'b1;
                        pulse_total_reg   <= pulse_total_reg + 1'b1;
                        if (!active_reg) begin
                            active_reg       <= 1'b1;
                            active_start_reg <= in_ms_reg;
                        end
                    end
                    state_reg <= ST_PLAN;
                end
                ST_PLAN: begin
                    priority if (!in_poll_reg) begin
                        state_reg <= ST_OUT;
                    end else if (period_reg != '0) begin
                        state_reg <= ST_DIV;
                    end else begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_DIV: begin
                    if (div_res.done) begin
                        freq_reg  <= div_res.quotient;
                        rpm_reg   <= rpm_calc;
                        state_reg <= ST_MUL_VEL;
                    end
                end
                ST_MUL_VEL: begin
                    state_reg <= ST_MUL_DIV5;
                end
                ST_MUL_DIV5: begin
                    state_reg <= ST_VEL;
                end
                ST_VEL: begin
                    velocity_reg <= prod_reg[RECIP5_SHIFT +: VEL_W];
                    state_reg    <= ST_MUL_DIST;
                end
                ST_MUL_DIST: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (dist_seen_reg) begin
                        distance_reg <= distance_reg + prod_reg[DIST_W-1:0];
                    end
                    last_dist_ms_reg <= in_ms_reg;
                    dist_seen_reg    <= 1'b1;
                    state_reg        <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (active_reg) begin
                        if (quiet_gap > TIME_W'(quiet_reg)) begin
                            active_reg       <= 1'b0;
                            active_accum_reg <= active_accum_reg + (in_ms_reg - active_start_reg);
                        end
                    end else if (pulse_seen_reg && (quiet_gap > TIME_W'(idle_reg))) begin
                        // long idle: clear all measures, keep the accepted edge stamp
                        period_reg       <= '0;
                        freq_reg         <= '0;
                        rpm_reg          <= '0;
                        velocity_reg     <= '0;
                        distance_reg     <= '0;
                        pulse_total_reg  <= '0;
                        active_accum_reg <= '0;
                        dist_seen_reg    <= 1'b0;
                        last_dist_ms_reg <= '0;
                        pulse_seen_reg   <= 1'b0;
                        last_pulse_reg   <= '0;
                        prev_edge_reg    <= '0;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg     <= 1'b1;
                        m_freq_reg      <= freq_reg;
                        m_rpm_reg       <= rpm_reg;
                        m_vel_reg       <= velocity_reg;
                        m_dist_reg      <= distance_reg;
                        m_holes_reg     <= pulse_total_reg;
                        m_active_ms_reg <= active_accum_reg;
                        m_active_reg    <= active_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_frequency_hz   = m_freq_reg;
    assign m_rpm_value      = m_rpm_reg;
    assign m_velocity       = m_vel_reg;
    assign m_distance_10um  = m_dist_reg;
    assign m_hole_count     = m_holes_reg;
    assign m_active_time_ms = m_active_ms_reg;
    assign m_signal_active  = m_active_reg;

endmodule

/* verif/odometer_check.sv */
// Watching checker for pulse_tachometer_odometer_core: predicts each reading and compares.
// Depends on pto_pkg. The testbench top instantiates it beside the core.
module odometer_check import pto_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [TIME_W-1:0] s_time_us,
    input  logic [TIME_W-1:0] s_time_ms,
    input  logic              s_edge_req,
    input  logic              s_poll,

    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [FREQ_W-1:0] m_frequency_hz,
    input  logic [RPM_W-1:0]  m_rpm_value,
    input  logic [VEL_W-1:0]  m_velocity,
    input  logic [DIST_W-1:0] m_distance_10um,
    input  logic [TIME_W-1:0] m_hole_count,
    input  logic [TIME_W-1:0] m_active_time_ms,
    input  logic              m_signal_active,

    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,

    output int                mismatches,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [RPM_W-1:0]  rpm;
        logic [VEL_W-1:0]  vel;
        logic [DIST_W-1:0] distance;
        logic [TIME_W-1:0] holes;
        logic [TIME_W-1:0] active_ms;
        logic              active;
    } reading_t;

    reading_t readings_due[$];
    int       results_seen;

    // register copies
    logic [STROKE_W-1:0] stroke_q8;
    logic [DEB_W-1:0]    debounce_us;
    logic [QUIET_W-1:0]  quiet_lim_ms;
    logic [IDLE_W-1:0]   idle_lim_ms;

    // measurement state
    logic [TIME_W-1:0] prev_edge_us, accepted_edge_us, period_us, last_pulse_ms;
    logic [TIME_W-1:0] pulse_total, active_start_ms, active_accum_ms, last_dist_ms;
    logic              active, pulse_seen, dist_seen;
    logic [DIST_W-1:0] dist_accum;
    logic [FREQ_W-1:0] freq_reg;
    logic [RPM_W-1:0]  rpm_reg;
    logic [VEL_W-1:0]  vel_reg;

    task automatic report_fault(input string msg);
        mismatches++;
        if (mismatches <= 60)
            $display("[%0t] %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got, want);
        if (got !== want)
            report_fault($sformatf("result %0d %s: got %0d, expected %0d",
                                   results_seen, name, got, want));
    endtask

    task automatic clear_measures();
        period_us       = '0;
        freq_reg        = '0;
        rpm_reg         = '0;
        vel_reg         = '0;
        dist_accum      = '0;
        pulse_total     = '0;
        active_accum_ms = '0;
        dist_seen       = 1'b0;
        last_dist_ms    = '0;
        pulse_seen      = 1'b0;
        last_pulse_ms   = '0;
        prev_edge_us    = '0;
    endtask

    task automatic advance_odometer(input logic [TIME_W-1:0] us, ms, input logic pulse, rd);
        logic [63:0]       hz;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] quiet_ms;
        reading_t          r;
        // edge first; debounce on the wrapped gap since the last accepted edge
        if (pulse && TIME_W'(us - prev_edge_us) >= TIME_W'(debounce_us)) begin
            prev_edge_us     = us;
            period_us        = us - accepted_edge_us;
            accepted_edge_us = us;
            last_pulse_ms    = ms;
            pulse_seen       = 1'b1;
            pulse_total      = pulse_total + 1'b1;
            if (!active) begin
                active          = 1'b1;
                active_start_ms = ms;
            end
        end
        if (rd) begin
            if (period_us != '0) begin
                hz      = 64'd1000000 / 64'(period_us);
                freq_reg = FREQ_W'(hz);
                rpm_reg  = RPM_W'(hz * 64'd60);
                vel_reg  = VEL_W'((hz * 64'(stroke_q8)) / 64'd2560);
                if (dist_seen) begin
                    elapsed    = ms - last_dist_ms;
                    dist_accum = DIST_W'(64'(dist_accum) + 64'(vel_reg) * 64'(elapsed));
                end
                last_dist_ms = ms;
                dist_seen    = 1'b1;
            end
            quiet_ms = ms - last_pulse_ms;
            if (active) begin
                if (quiet_ms > TIME_W'(quiet_lim_ms)) begin
                    active          = 1'b0;
                    active_accum_ms = active_accum_ms + (ms - active_start_ms);
                end
            end else if (pulse_seen && quiet_ms > TIME_W'(idle_lim_ms)) begin
                clear_measures();
            end
        end
        r.freq      = freq_reg;
        r.rpm       = rpm_reg;
        r.vel       = vel_reg;
        r.distance  = dist_accum;
        r.holes     = pulse_total;
        r.active_ms = active_accum_ms;
        r.active    = active;
        readings_due.push_back(r);
    endtask

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            stroke_q8        = STROKE_RST;
            debounce_us      = DEB_RST;
            quiet_lim_ms     = QUIET_RST;
            idle_lim_ms      = IDLE_RST;
            clear_measures();
            accepted_edge_us = '0;
            active           = 1'b0;
            active_start_ms  = '0;
            readings_due.delete();
            results_seen     = 0;
            mismatches       = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STROKE:   stroke_q8    = cfg_data[STROKE_W-1:0];
                    CFG_DEBOUNCE: debounce_us  = cfg_data[DEB_W-1:0];
                    CFG_QUIET:    quiet_lim_ms = cfg_data[QUIET_W-1:0];
                    CFG_IDLE:     idle_lim_ms  = cfg_data[IDLE_W-1:0];
                    default: ;
                endcase
            end
            // retire before predicting: a result never belongs to a same-edge input
            if (m_valid && m_ready) begin
                results_seen++;
                if (readings_due.size() == 0) begin
                    report_fault($sformatf("result %0d arrived with no reading due",
                                           results_seen));
                end else begin
                    want = readings_due.pop_front();
                    check_field("frequency_hz",   m_frequency_hz,   want.freq);
                    check_field("rpm_value",      m_rpm_value,      want.rpm);
                    check_field("velocity",       m_velocity,       want.vel);
                    check_field("distance_10um",  m_distance_10um,  want.distance);
                    check_field("hole_count",     m_hole_count,     want.holes);
                    check_field("active_time_ms", m_active_time_ms, want.active_ms);
                    check_field("signal_active",  m_signal_active,  want.active);
                end
            end
            if (s_valid && s_ready)
                advance_odometer(s_time_us, s_time_ms, s_edge_req, s_poll);
        end
        outstanding = readings_due.size();
    end

endmodule

/* verif/tb.sv */
// Testbench top for pulse_tachometer_odometer_core: clock, reset, stimulus and verdict.
// Depends on pto_pkg, the core RTL and odometer_check (prediction and comparison).
module tb import pto_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400_000;
    // long receiver hold-off: the core fills up and drops s_ready
    localparam int HOLD_OFF    = 600;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [TIME_W-1:0] s_time_us;
    logic [TIME_W-1:0] s_time_ms;
    logic              s_edge_req;
    logic              s_poll;
    logic              m_valid;
    logic              m_ready;
    logic [FREQ_W-1:0] m_frequency_hz;
    logic [RPM_W-1:0]  m_rpm_value;
    logic [VEL_W-1:0]  m_velocity;
    logic [DIST_W-1:0] m_distance_10um;
    logic [TIME_W-1:0] m_hole_count;
    logic [TIME_W-1:0] m_active_time_ms;
    logic              m_signal_active;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    int                mismatches;
    int                outstanding;
    int                cycles;
    bit                pressure_go;
    int                sender_calm;
    // running timestamps for well-formed pulse trains
    logic [TIME_W-1:0] track_us, track_ms;

    pulse_tachometer_odometer_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_time_us        (s_time_us),
        .s_time_ms        (s_time_ms),
        .s_edge_req       (s_edge_req),
        .s_poll           (s_poll),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frequency_hz   (m_frequency_hz),
        .m_rpm_value      (m_rpm_value),
        .m_velocity       (m_velocity),
        .m_distance_10um  (m_distance_10um),
        .m_hole_count     (m_hole_count),
        .m_active_time_ms (m_active_time_ms),
        .m_signal_active  (m_signal_active),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    odometer_check odo_chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_time_us        (s_time_us),
        .s_time_ms        (s_time_ms),
        .s_edge_req       (s_edge_req),
        .s_poll           (s_poll),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frequency_hz   (m_frequency_hz),
        .m_rpm_value      (m_rpm_value),
        .m_velocity       (m_velocity),
        .m_distance_10um  (m_distance_10um),
        .m_hole_count     (m_hole_count),
        .m_active_time_ms (m_active_time_ms),
        .m_signal_active  (m_signal_active),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    // 20 ns clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Idle length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 8);
        else
            return $urandom_range(9, 40);
    endfunction

    // Sender gap before a transaction; occasional calm stretches with none at all
    function automatic int sender_gap();
        if (sender_calm > 0) begin
            sender_calm--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            sender_calm = $urandom_range(20, 60);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return gap_len();
    endfunction

    // Result side: random stalls, calm stretches, and one long hold-off on request
    initial begin
        int r;
        int stall_left;
        int calm_left;
        bit held_off;
        stall_left = 0;
        calm_left  = 0;
        held_off   = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (pressure_go && !held_off) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 3)
                    calm_left = $urandom_range(30, 120);
                else if (r < 30)
                    stall_left = gap_len();
            end
        end
    end

    // One input transaction; valid is held until the core takes it
    task automatic send_reading(input logic [TIME_W-1:0] us, ms, input logic pulse, rd);
        int gap;
        gap = sender_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_time_us  <= us;
        s_time_ms  <= ms;
        s_edge_req <= pulse;
        s_poll     <= rd;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait for every predicted reading to come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Registers only change with the core idle
    task automatic program_setting(input logic [CFG_W-1:0] stroke, deb, quiet, idle_lim);
        drain();
        write_reg(CFG_STROKE,   stroke);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_QUIET,    quiet);
        write_reg(CFG_IDLE,     idle_lim);
    endtask

    // Mostly plausible pulse trains with advancing timestamps, some pure noise
    task automatic run_random(input int count);
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] us, ms;
        logic              pulse, rd;
        // start anywhere, often just short of the 32-bit wrap
        if ($urandom_range(0, 1) == 0) begin
            track_us = $urandom;
            track_ms = $urandom;
        end else begin
            track_us = $urandom_range(32'hFF00_0000, 32'hFFFF_FFFF);
            track_ms = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
        end
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 12) begin
                us    = $urandom;
                ms    = $urandom;
                pulse = $urandom_range(0, 1);
                rd    = $urandom_range(0, 1);
            end else begin
                case ($urandom_range(0, 9))
                    0:          dt = $urandom_range(0, 3);           // near-zero period
                    1, 2:       dt = $urandom_range(0, 2500);        // bounce territory
                    3, 4, 5, 6: dt = $urandom_range(1000, 100_000);
                    7, 8:       dt = $urandom_range(100_000, 3_000_000);
                    default:    dt = $urandom_range(0, 50_000_000);  // long silence
                endcase
                track_us = track_us + dt;
                track_ms = track_ms + dt / 1000;
                if ($urandom_range(0, 7) == 0)
                    track_ms = track_ms + $urandom_range(0, 5);
                us    = track_us;
                ms    = track_ms;
                pulse = ($urandom_range(0, 9) < 7);
                rd    = $urandom_range(0, 1);
            end
            send_reading(us, ms, pulse, rd);
        end
    endtask

    initial begin
        s_valid     = 1'b0;
        s_time_us   = '0;
        s_time_ms   = '0;
        s_edge_req  = 1'b0;
        s_poll      = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_STROKE;
        cfg_data    = '0;
        sender_calm = 0;
        aresetn     = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed, reset register values ---
        // poll with nothing measured yet: zero period leaves everything at zero
        send_reading(32'd0, 32'd0, 1'b0, 1'b1);
        // edge within the debounce window of the reset stamp is dropped
        send_reading(32'd500, 32'd0, 1'b1, 1'b0);
        send_reading(32'd500, 32'd0, 1'b1, 1'b1);
        // first accepted edge, first distance poll only takes the stamp
        send_reading(32'd5000, 32'd5, 1'b1, 1'b1);
        // bounce, then a clean edge with a distance step
        send_reading(32'd5400, 32'd5, 1'b1, 1'b0);
        send_reading(32'd10000, 32'd10, 1'b1, 1'b1);
        send_reading(32'd15000, 32'd200, 1'b0, 1'b1);
        // quiet timeout stops the active timer
        send_reading(32'd20000, 32'd1500, 1'b0, 1'b1);
        send_reading(32'd20000, 32'd1600, 1'b0, 1'b1);
        // long idle clears all measures, then a poll with zero period
        send_reading(32'd20000, 32'd40000, 1'b0, 1'b1);
        send_reading(32'd20000, 32'd40001, 1'b0, 1'b1);
        // timestamps across the wrap; huge periods give zero frequency
        send_reading(32'hFFFF_F000, 32'hFFFF_FFF0, 1'b1, 1'b1);
        send_reading(32'h0000_0800, 32'h0000_0010, 1'b1, 1'b1);
        send_reading(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_reading(32'h1234_5678, 32'h0000_0400, 1'b0, 1'b1);
        // neither edge nor poll
        send_reading(32'd123, 32'd456, 1'b0, 1'b0);

        // random phase at reset values, with the long receiver hold-off
        pressure_go = 1'b1;
        run_random(90);

        // low extremes: no debounce, instant timeouts, widest stroke
        program_setting(32'd65535, 32'd0, 32'd0, 32'd0);
        run_random(90);
        // high extremes
        program_setting(32'd0, 32'd1_000_000, 32'd1_000_000, 32'd4_000_000);
        run_random(90);
        // reset values, written explicitly
        program_setting(32'd896, 32'd1000, 32'd1000, 32'd30000);
        run_random(90);
        // full-width data: bits beyond each register are dropped
        program_setting($urandom, $urandom, $urandom, $urandom);
        run_random(90);
        // random settings at scales the pulse trains exercise
        program_setting($urandom_range(0, 65535), $urandom_range(0, 5000),
                        $urandom_range(0, 3000), $urandom_range(0, 20000));
        run_random(90);

        drain();
        // room for any stray late result
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
hdl/pto_pkg.sv
hdl/pto_div.sv
hdl/pulse_tachometer_odometer_core.sv
verif/odometer_check.sv
verif/tb.sv
